// ===== design/ibis_telegram_framer_defines.svh =====
// Assertion macros shared by the framer modules.
// Each macro expects signals named clock and reset in the scope of use.
`ifndef IBIS_TELEGRAM_FRAMER_DEFINES_SVH
`define IBIS_TELEGRAM_FRAMER_DEFINES_SVH

`ifndef ASSERT_OFF
// Check cons in the same cycle as ante.
`define ITF_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
// Check cons in the cycle after ante.
`define ITF_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define ITF_ASSERT_SAME(lbl, ante, cons, msg)
`define ITF_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== design/itf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package itf_pkg;

   localparam logic [7:0] CHK_INIT = 8'h7F;
   localparam logic [7:0] CR_CODE  = 8'h0D;
   localparam logic [7:0] LF_CODE  = 8'h0A;
   localparam logic [7:0] ESC_CODE = 8'h5F;

   // Decoded item handed from the decoder to the emitter.
   typedef struct packed {
      logic       have;    // a character byte goes out
      logic [7:0] char_b;  // that character byte
      logic       fin;     // CR and checksum follow
      logic [7:0] chk;     // final checksum, CR included
   } itf_entry_type;

endpackage

`default_nettype wire

// ===== design/itf_channels.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface itf_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic       end_of_message;

   modport source (output valid, output char_code, output end_of_message, input ready);
   modport sink   (input valid, input char_code, input end_of_message, output ready);
endinterface

interface itf_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       last_byte;

   modport source (output valid, output out_byte, output last_byte, input ready);
   modport sink   (input valid, input out_byte, input last_byte, output ready);
endinterface

`default_nettype wire

// ===== design/ibis_telegram_framer.sv =====
// IBIS telegram framer.
// req_if carries one Latin-1 character per item (char_code) and a flag
// end_of_message on the final character of a message. rsp_if carries the
// telegram bytes: decoded characters, then CR, then the XOR checksum with
// last_byte set. Escapes ('__', '_n', '_A'..'_F', '_0'..'_9') are decoded
// and umlaut codes are mapped to their IBIS replacements; unknown escapes
// and a lone '_' at the end of a message are dropped.
// A result byte is offered on rsp_if in the cycle after its item is
// accepted. Throughput: one item per cycle while each item yields at most
// one byte and the receiver takes every byte; the final character holds
// the single result register through character, CR and checksum, so
// req_if.ready drops there. Items that yield no byte bypass the register.
// A stalled receiver holds the current byte; the next item is still taken
// in the cycle the last byte of the pending entry leaves.
// Reset (synchronous, active high) clears the escape flag, sets the
// checksum to 0x7F and empties the result register.
`timescale 1ns / 1ps
`default_nettype none

module ibis_telegram_framer import itf_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   itf_req_if.sink   req_if,
   itf_rsp_if.source rsp_if
);

   itf_entry_type entry;
   logic          in_fire;
   logic          in_ready;

   // accept an item when the emitter can take its decoded entry
   assign req_if.ready = in_ready;
   assign in_fire      = req_if.valid && in_ready;

   // decode the character and advance escape flag and checksum
   itf_decoder u_decoder (
      .clock          (clock),
      .reset          (reset),
      .accept         (in_fire),
      .char_code      (req_if.char_code),
      .end_of_message (req_if.end_of_message),
      .entry          (entry)
   );

   // hold the entry and step through character, CR and checksum
   itf_emitter u_emitter (
      .clock     (clock),
      .reset     (reset),
      .in_fire   (in_fire),
      .entry     (entry),
      .in_ready  (in_ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .out_byte  (rsp_if.out_byte),
      .last_byte (rsp_if.last_byte)
   );

endmodule

`default_nettype wire

// ===== design/itf_decoder.sv =====
`timescale 1ns / 1ps
`default_nettype none

module itf_decoder import itf_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          accept,
   input  logic [7:0]    char_code,
   input  logic          end_of_message,
   output itf_entry_type entry
);

   logic       escape_pending_ff, escape_pending_in;
   logic [7:0] checksum_ff, checksum_in;
   logic       esc_next;
   logic       have;
   logic [7:0] char_b;
   logic [7:0] chk_sum;

   always_comb begin
      have     = 1'b0;
      char_b   = char_code;
      esc_next = escape_pending_ff;
      if (escape_pending_ff) begin
         esc_next = 1'b0;
         unique case (char_code) inside
            ESC_CODE: begin
               have   = 1'b1;
               char_b = ESC_CODE;
            end
            8'h6E: begin
               have   = 1'b1;
               char_b = LF_CODE;
            end
            [8'h41:8'h46]: begin
               // map A..F onto ':'..'?'
               have   = 1'b1;
               char_b = char_code - 8'd7;
            end
            [8'h30:8'h39]: begin
               have   = 1'b1;
               char_b = char_code;
            end
            default: begin
               // drop unknown escape
               have   = 1'b0;
               char_b = char_code;
            end
         endcase
      end else if (char_code == ESC_CODE) begin
         esc_next = 1'b1;
      end else begin
         have = 1'b1;
         unique case (char_code)
            8'hC4:   char_b = 8'h5B;
            8'hE4:   char_b = 8'h7B;
            8'hD6:   char_b = 8'h5C;
            8'hF6:   char_b = 8'h7C;
            8'hDC:   char_b = 8'h5D;
            8'hFC:   char_b = 8'h7D;
            8'hDF:   char_b = 8'h7E;
            default: char_b = char_code;
         endcase
      end
   end

   assign chk_sum = have ? (checksum_ff ^ char_b) : checksum_ff;

   always_comb begin
      entry.have   = have;
      entry.char_b = char_b;
      entry.fin    = end_of_message;
      entry.chk    = chk_sum ^ CR_CODE;
   end

   always_comb begin
      escape_pending_in = escape_pending_ff;
      checksum_in       = checksum_ff;
      if (accept) begin
         if (end_of_message) begin
            escape_pending_in = 1'b0;
            checksum_in       = CHK_INIT;
         end else begin
            escape_pending_in = esc_next;
            checksum_in       = chk_sum;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         escape_pending_ff <= 1'b0;
         checksum_ff       <= CHK_INIT;
      end else begin
         escape_pending_ff <= escape_pending_in;
         checksum_ff       <= checksum_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/itf_emitter.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "ibis_telegram_framer_defines.svh"

module itf_emitter import itf_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_fire,
   input  itf_entry_type entry,
   output logic          in_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output logic [7:0]    out_byte,
   output logic          last_byte
);

   localparam logic [1:0] PH_CHAR = 2'd0;
   localparam logic [1:0] PH_CR   = 2'd1;
   localparam logic [1:0] PH_CHK  = 2'd2;

   itf_entry_type entry_ff, entry_in;
   logic          full_ff, full_in;
   logic [1:0]    phase_ff, phase_in;
   logic          load;
   logic          fire;
   logic          done;

   assign fire      = full_ff && rsp_ready;
   assign done      = ((phase_ff == PH_CHAR) && !entry_ff.fin) || (phase_ff == PH_CHK);
   assign in_ready  = !full_ff || (fire && done);
   assign load      = in_fire && (entry.have || entry.fin);
   assign rsp_valid = full_ff;

   always_comb begin
      out_byte  = entry_ff.char_b;
      last_byte = 1'b0;
      unique case (phase_ff)
         PH_CHAR: out_byte = entry_ff.char_b;
         PH_CR:   out_byte = CR_CODE;
         PH_CHK: begin
            out_byte  = entry_ff.chk;
            last_byte = 1'b1;
         end
         default: out_byte = entry_ff.char_b;
      endcase
   end

   always_comb begin
      entry_in = entry_ff;
      full_in  = full_ff;
      phase_in = phase_ff;
      if (load) begin
         entry_in = entry;
         full_in  = 1'b1;
         phase_in = entry.have ? PH_CHAR : PH_CR;
      end else if (fire) begin
         if (done) begin
            full_in = 1'b0;
         end else begin
            unique case (phase_ff)
               PH_CHAR: phase_in = PH_CR;
               PH_CR:   phase_in = PH_CHK;
               default: phase_in = PH_CHK;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff  <= 1'b0;
         phase_ff <= PH_CHAR;
      end else begin
         full_ff  <= full_in;
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   `ITF_ASSERT_NEXT(a_cr_then_chk, fire && (phase_ff == PH_CR), full_ff && (phase_ff == PH_CHK), "checksum must follow CR")
   `ITF_ASSERT_NEXT(a_chk_drains, fire && (phase_ff == PH_CHK) && !load, !full_ff, "entry must drain after checksum")
   `ITF_ASSERT_SAME(a_last_has_fin, rsp_valid && last_byte, entry_ff.fin, "last byte without end of message")
   `ITF_ASSERT_SAME(a_stall_full, !in_ready, full_ff && !(fire && done), "input stalled while entry free")

endmodule

`default_nettype wire

// ===== dv/ibis_telegram_framer_tb.sv =====
`timescale 1ns / 1ps

module ibis_telegram_framer_tb;
   import itf_pkg::*;

   // Character codes the escape decoder and the umlaut map care about.
   localparam logic [7:0] CH_LOWER_N = 8'h6E;
   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_UPPER_F = 8'h46;
   localparam logic [7:0] CH_UPPER_G = 8'h47;
   localparam logic [7:0] CH_AT      = 8'h40;
   localparam logic [7:0] CH_DIGIT_0 = 8'h30;
   localparam logic [7:0] CH_DIGIT_9 = 8'h39;
   localparam logic [7:0] CH_SLASH   = 8'h2F;
   localparam logic [7:0] CH_COLON   = 8'h3A;
   localparam logic [7:0] CH_UPPER_H = 8'h48;
   localparam logic [7:0] UML_A_UP   = 8'hC4;
   localparam logic [7:0] UML_A_LO   = 8'hE4;
   localparam logic [7:0] UML_O_UP   = 8'hD6;
   localparam logic [7:0] UML_O_LO   = 8'hF6;
   localparam logic [7:0] UML_U_UP   = 8'hDC;
   localparam logic [7:0] UML_U_LO   = 8'hFC;
   localparam logic [7:0] SHARP_S    = 8'hDF;
   localparam logic [7:0] IBIS_A_UP  = 8'h5B;  // '['
   localparam logic [7:0] IBIS_A_LO  = 8'h7B;  // '{'
   localparam logic [7:0] IBIS_O_UP  = 8'h5C;  // '\'
   localparam logic [7:0] IBIS_O_LO  = 8'h7C;  // '|'
   localparam logic [7:0] IBIS_U_UP  = 8'h5D;  // ']'
   localparam logic [7:0] IBIS_U_LO  = 8'h7D;  // '}'
   localparam logic [7:0] IBIS_SZ    = 8'h7E;  // '~'

   localparam int RANDOM_ITEMS = 330;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int TAIL_CYCLES  = 8;

   typedef struct packed {
      logic [7:0] code;
      logic       eom;
      logic       hold;   // wait for every outstanding byte before offering
   } char_item_type;

   typedef struct packed {
      logic [7:0] value;
      logic       last;
   } tele_byte_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   itf_req_if req_bus ();
   itf_rsp_if rsp_bus ();

   ibis_telegram_framer i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus)
   );

   always #1 clock = ~clock;

   // Pending characters and the telegram bytes still owed by the block.
   char_item_type char_backlog[$];
   tele_byte_type telegram_due[$];

   // Shadow of the framer state.
   logic       esc_open;
   logic [7:0] chk_acc;

   int  cycle_count    = 0;
   int  mismatch_count = 0;
   int  queued_count   = 0;
   bit  hold_next      = 1'b0;
   bit  req_fired      = 1'b0;
   bit  rsp_fired      = 1'b0;
   bit  send_busy      = 1'b0;
   bit  send_burst     = 1'b0;
   bit  take_burst     = 1'b0;
   int  send_gap       = 0;
   int  take_stall     = 0;
   char_item_type cur_item;
   tele_byte_type got_byte;

   task automatic report_mismatch(input string what);
      $display("MISMATCH cycle %0d: %s", cycle_count, what);
      mismatch_count++;
   endtask

   // Frame one character: decode escapes, map umlauts, fold every emitted
   // byte into the checksum and close the telegram on end of message.
   function automatic void frame_char(input logic [7:0] ch, input logic eom);
      logic [7:0] b;
      logic       have;
      have = 1'b0;
      b    = ch;
      if (esc_open) begin
         esc_open = 1'b0;
         if (ch == ESC_CODE) begin
            b    = ESC_CODE;
            have = 1'b1;
         end else if (ch == CH_LOWER_N) begin
            b    = LF_CODE;
            have = 1'b1;
         end else if (ch >= CH_UPPER_A && ch <= CH_UPPER_F) begin
            b    = CH_COLON + (ch - CH_UPPER_A);
            have = 1'b1;
         end else if (ch >= CH_DIGIT_0 && ch <= CH_DIGIT_9) begin
            have = 1'b1;
         end
         // anything else: unknown escape, drop both characters
      end else if (ch == ESC_CODE) begin
         esc_open = 1'b1;
      end else begin
         have = 1'b1;
         case (ch)
            UML_A_UP: b = IBIS_A_UP;
            UML_A_LO: b = IBIS_A_LO;
            UML_O_UP: b = IBIS_O_UP;
            UML_O_LO: b = IBIS_O_LO;
            UML_U_UP: b = IBIS_U_UP;
            UML_U_LO: b = IBIS_U_LO;
            SHARP_S:  b = IBIS_SZ;
            default:  b = ch;
         endcase
      end
      if (have) begin
         chk_acc = chk_acc ^ b;
         telegram_due.push_back('{value: b, last: 1'b0});
      end
      if (eom) begin
         // a lone escape on the final character is simply dropped
         chk_acc = chk_acc ^ CR_CODE;
         telegram_due.push_back('{value: CR_CODE, last: 1'b0});
         telegram_due.push_back('{value: chk_acc, last: 1'b1});
         esc_open = 1'b0;
         chk_acc  = CHK_INIT;
      end
   endfunction

   function automatic logic [7:0] umlaut_code(input int idx);
      case (idx)
         0:       return UML_A_UP;
         1:       return UML_A_LO;
         2:       return UML_O_UP;
         3:       return UML_O_LO;
         4:       return UML_U_UP;
         5:       return UML_U_LO;
         default: return SHARP_S;
      endcase
   endfunction

   task automatic add_char(input logic [7:0] code, input logic eom);
      char_backlog.push_back('{code: code, eom: eom,
                               hold: hold_next || ($urandom_range(0, 59) == 0)});
      hold_next = 1'b0;
      queued_count++;
   endtask

   // Monitor: check the byte leaving, then predict from the character taken.
   // Bytes appear no earlier than the cycle after their character, so checking
   // before predicting in the same edge is safe.
   always @(posedge clock) begin
      req_fired = 1'b0;
      rsp_fired = 1'b0;
      cycle_count++;
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            rsp_fired = 1'b1;
            if (telegram_due.size() == 0) begin
               report_mismatch($sformatf("unexpected byte %02h last %0b",
                                         rsp_bus.out_byte, rsp_bus.last_byte));
            end else begin
               got_byte = telegram_due.pop_front();
               if (rsp_bus.out_byte !== got_byte.value)
                  report_mismatch($sformatf("out_byte %02h, want %02h",
                                            rsp_bus.out_byte, got_byte.value));
               if (rsp_bus.last_byte !== got_byte.last)
                  report_mismatch($sformatf("last_byte %0b, want %0b",
                                            rsp_bus.last_byte, got_byte.last));
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            req_fired = 1'b1;
            frame_char(req_bus.char_code, req_bus.end_of_message);
         end
      end
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("Regression FAIL");
         $finish;
      end
   end

   // Sender: offer characters from the backlog with random gaps, switching
   // now and then into a burst with no gaps at all.
   always @(negedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_fired) begin
            send_busy = 1'b0;
            if ($urandom_range(0, 31) == 0)
               send_burst = !send_burst;
            send_gap = send_burst ? 0 : $urandom_range(0, 8);
         end
         if (!send_busy) begin
            if (send_gap > 0) begin
               send_gap--;
               req_bus.valid     <= 1'b0;
               req_bus.char_code <= 8'($urandom);
            end else if (char_backlog.size() != 0 &&
                         !(char_backlog[0].hold && telegram_due.size() != 0)) begin
               cur_item = char_backlog.pop_front();
               req_bus.valid          <= 1'b1;
               req_bus.char_code      <= cur_item.code;
               req_bus.end_of_message <= cur_item.eom;
               send_busy = 1'b1;
            end else begin
               // hold off: backlog empty or draining before a held item
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: stall at random before each byte, switching now and then into a burst with no stalls at all.
   always @(negedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_fired) begin
            if ($urandom_range(0, 31) == 0)
               take_burst = !take_burst;
            take_stall = take_burst ? 0 : $urandom_range(0, 8);
         end
         if (take_stall > 0) begin
            take_stall--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   initial begin : stimulus
      int msg_len;
      int pick;
      bit noise;
      bit last;

      req_bus.valid          = 1'b0;
      req_bus.char_code      = 8'h00;
      req_bus.end_of_message = 1'b0;
      rsp_bus.ready          = 1'b0;
      esc_open               = 1'b0;
      chk_acc                = CHK_INIT;

      // Directed: zero code and all-ones as plain bytes, then every umlaut.
      add_char(8'h00, 1'b0);
      add_char(8'hFF, 1'b0);
      for (int i = 0; i < 7; i++)
         add_char(umlaut_code(i), i == 6);
      // Every escape class with its range ends.
      add_char(ESC_CODE, 1'b0);  add_char(ESC_CODE, 1'b0);
      add_char(ESC_CODE, 1'b0);  add_char(CH_LOWER_N, 1'b0);
      add_char(ESC_CODE, 1'b0);  add_char(CH_UPPER_A, 1'b0);
      add_char(ESC_CODE, 1'b0);  add_char(CH_UPPER_F, 1'b0);
      add_char(ESC_CODE, 1'b0);  add_char(CH_DIGIT_0, 1'b0);
      add_char(ESC_CODE, 1'b0);  add_char(CH_DIGIT_9, 1'b0);
      // Zero code after an escape is an unknown escape.
      add_char(ESC_CODE, 1'b0);  add_char(8'h00, 1'b0);
      // Lone escape on the final character.
      add_char(ESC_CODE, 1'b1);
      // One-character telegram.
      add_char(CH_UPPER_H, 1'b1);

      // Random: mostly well-formed messages, some plain noise.
      hold_next = 1'b1;
      while (queued_count < RANDOM_ITEMS) begin
         msg_len = $urandom_range(1, 12);
         noise   = ($urandom_range(0, 9) == 0);
         for (int k = 0; k < msg_len; k++) begin
            last = (k == msg_len - 1);
            pick = $urandom_range(0, 19);
            if (noise) begin
               add_char(8'($urandom), $urandom_range(0, 7) == 0);
            end else if (pick < 6) begin
               add_char(8'($urandom), last);
            end else if (pick < 9) begin
               add_char(umlaut_code($urandom_range(0, 6)), last);
            end else if (pick < 15) begin
               add_char(ESC_CODE, 1'b0);
               case ($urandom_range(0, 3))
                  0:       add_char(ESC_CODE, last);
                  1:       add_char(CH_LOWER_N, last);
                  2:       add_char(CH_UPPER_A + 8'($urandom_range(0, 5)), last);
                  default: add_char(CH_DIGIT_0 + 8'($urandom_range(0, 9)), last);
               endcase
            end else if (pick < 17) begin
               // unknown escapes, near the edges of the known ranges
               add_char(ESC_CODE, 1'b0);
               case ($urandom_range(0, 4))
                  0:       add_char(CH_AT, last);
                  1:       add_char(CH_UPPER_G, last);
                  2:       add_char(CH_SLASH, last);
                  3:       add_char(CH_COLON, last);
                  default: add_char(8'($urandom), last);
               endcase
            end else if (pick == 17 && last) begin
               add_char(ESC_CODE, 1'b1);
            end else begin
               add_char(8'($urandom_range(8'h20, 8'h7E)), last);
            end
         end
      end

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Drain: everything offered, taken and answered.
      while (char_backlog.size() != 0 || send_busy || telegram_due.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (telegram_due.size() != 0)
         report_mismatch($sformatf("%0d bytes never arrived", telegram_due.size()));
      if (mismatch_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+design
design/itf_pkg.sv
design/itf_channels.sv
design/itf_decoder.sv
design/itf_emitter.sv
design/ibis_telegram_framer.sv
dv/ibis_telegram_framer_tb.sv
